// ===== sv/ske_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ske_pkg;

    // Field widths
    localparam int VALUE_W   = 64;
    localparam int KEY_W     = 64;
    localparam int CFG_IDX_W = 1;

    // Input tuser layout, lowest bit first: command, is_null
    localparam int IN_USER_W  = 2;
    // Output tdata layout, lowest bit first: marker, key, zero fill to 72 bits
    localparam int OUT_DATA_W = 72;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NULLABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'd1;

    // Value kinds carried in command
    localparam logic CMD_INT    = 1'b0;
    localparam logic CMD_DOUBLE = 1'b1;

    // Encoding constants
    localparam logic [KEY_W-1:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [15:0]      TOP16_SET = 16'h8000;
    localparam logic [15:0]      EXP_STEP  = 16'd16;

    // Mode bits shared by the register file and the encoder
    typedef struct packed {
        logic nullable;
        logic descending;
    } ske_cfg_t;

endpackage

`default_nettype wire

// ===== sv/ske_encode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ske_encode (
    input  wire ske_pkg::ske_cfg_t           cfg,
    input  wire logic                        command,
    input  wire logic [ske_pkg::VALUE_W-1:0] value,
    input  wire logic                        is_null,
    output logic                             marker_present,
    output logic                             marker,
    output logic [ske_pkg::KEY_W-1:0]        key
);

    logic [ske_pkg::KEY_W-1:0] dbl_key;
    logic [ske_pkg::KEY_W-1:0] raw_key;
    logic [15:0]               dbl_top;

    // Raise the exponent of a positive double, wrapping in the top 16 bits
    assign dbl_top = (value[63:48] | ske_pkg::TOP16_SET) + ske_pkg::EXP_STEP;

    // Map a double pattern: both zeros to the sign bit, negatives inverted, positives raised
    always_comb
    begin
        if (value[62:0] == 63'd0)
        begin
            dbl_key = ske_pkg::SIGN_BIT;
        end
        else if (value[63])
        begin
            dbl_key = ~value;
        end
        else
        begin
            dbl_key = {dbl_top, value[47:0]};
        end
    end

    // Pick the key by kind, force zero for null
    always_comb
    begin
        if (is_null)
        begin
            raw_key = '0;
            marker  = 1'b0;
        end
        else
        begin
            raw_key = (command == ske_pkg::CMD_DOUBLE) ? dbl_key
                                                       : (value ^ ske_pkg::SIGN_BIT);
            marker  = cfg.nullable;
        end
    end

    // Invert for descending order; the marker is left as is
    assign key            = cfg.descending ? ~raw_key : raw_key;
    assign marker_present = cfg.nullable;

endmodule

`default_nettype wire

// ===== sv/sort_key_encoder.sv =====
// An accepted input beat passes the input register, then the result register, to its result beat.
// Throughput: one beat per cycle while m_axis_tready holds; input register, encoder logic, result register.
// A stalled result holds in the result register while the input register fills.
// Reset (rst_n low, asynchronous) empties both stages and clears nullable and
// descending to 0; the configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sort_key_encoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ske_pkg::VALUE_W-1:0]       s_axis_tdata,  // value
    input  wire logic [ske_pkg::IN_USER_W-1:0]     s_axis_tuser,  // command, is_null
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [ske_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // marker, key, zero fill
    output logic                                   m_axis_tuser,  // marker_present
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ske_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic                              cfg_data
);

    ske_pkg::ske_cfg_t cfg_reg;

    logic                          s1_valid_reg;
    logic [ske_pkg::VALUE_W-1:0]   s1_value_reg;
    logic                          s1_command_reg;
    logic                          s1_null_reg;

    logic                          m_valid_reg;
    logic                          m_present_reg;
    logic                          m_marker_reg;
    logic [ske_pkg::KEY_W-1:0]     m_key_reg;

    logic                          out_ready;
    logic                          enc_present;
    logic                          enc_marker;
    logic [ske_pkg::KEY_W-1:0]     enc_key;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ske_pkg::REG_NULLABLE:   cfg_reg.nullable   <= cfg_data;
                ske_pkg::REG_DESCENDING: cfg_reg.descending <= cfg_data;
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Advance when the result register is empty or being drained
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_value_reg   <= s_axis_tdata;
            s1_command_reg <= s_axis_tuser[0];
            s1_null_reg    <= s_axis_tuser[1];
        end
    end

    ske_encode u_encode (
        .cfg            (cfg_reg),
        .command        (s1_command_reg),
        .value          (s1_value_reg),
        .is_null        (s1_null_reg),
        .marker_present (enc_present),
        .marker         (enc_marker),
        .key            (enc_key)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_ready)
        begin
            m_present_reg <= enc_present;
            m_marker_reg  <= enc_marker;
            m_key_reg     <= enc_key;
        end
    end

    // Drive the result beat
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_present_reg;
    assign m_axis_tdata  = {{(ske_pkg::OUT_DATA_W - ske_pkg::KEY_W - 1){1'b0}},
                            m_key_reg, m_marker_reg};

    // Checks
    a_present_tracks_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_present_reg == cfg_reg.nullable))
        else $error("marker_present differs from nullable");

    a_no_marker_without_nullable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_present_reg) |-> !m_marker_reg)
        else $error("marker set while no marker is emitted");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_ready) |=> m_valid_reg)
        else $error("beat lost between input and result register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

// ===== tb/tb_sort_key_encoder.sv =====
`timescale 1ns / 1ps

module tb_sort_key_encoder;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic                      present;
        logic                      marker;
        logic [ske_pkg::KEY_W-1:0] key;
    } sort_key_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [ske_pkg::VALUE_W-1:0]       s_axis_tdata = '0;
    logic [ske_pkg::IN_USER_W-1:0]     s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [ske_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ske_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic                              cfg_data = 1'b0;

    // Shadow copy of the mode registers
    ske_pkg::ske_cfg_t mode = '0;
    sort_key_t         key_expect_q[$];
    int                mismatches = 0;
    int                cycle_count = 0;
    bit                no_idle = 1'b0;

    sort_key_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Compute the key one value maps to under the current mode
    function automatic sort_key_t predict_key(logic cmd, logic [ske_pkg::VALUE_W-1:0] value,
                                              logic is_null, ske_pkg::ske_cfg_t m);
        sort_key_t  r;
        logic [15:0] top;
        r.present = m.nullable;
        if (is_null)
        begin
            r.key    = '0;
            r.marker = 1'b0;
        end
        else
        begin
            r.marker = m.nullable;
            if (cmd == ske_pkg::CMD_INT)
                r.key = value ^ ske_pkg::SIGN_BIT;
            else if (value[62:0] == '0)
                r.key = ske_pkg::SIGN_BIT;
            else if (value[63])
                r.key = ~value;
            else
            begin
                top   = (value[63:48] | ske_pkg::TOP16_SET) + ske_pkg::EXP_STEP;
                r.key = {top, value[47:0]};
            end
        end
        if (m.descending)
            r.key = ~r.key;
        return r;
    endfunction

    // Send one value beat, optionally after an idle burst
    task automatic send_value(logic cmd, logic [ske_pkg::VALUE_W-1:0] value, logic is_null);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {is_null, cmd};
        do @(posedge clk); while (!s_axis_tready);
        key_expect_q.push_back(predict_key(cmd, value, is_null, mode));
    endtask

    // Hold off input until every expected key has come back
    task automatic wait_keys_drained();
        s_axis_tvalid <= 1'b0;
        while (key_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Present one register write and wait for its beat; valid stays up
    task automatic write_mode_reg(logic [ske_pkg::CFG_IDX_W-1:0] idx, logic d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ske_pkg::REG_NULLABLE)
            mode.nullable = d;
        else
            mode.descending = d;
    endtask

    task automatic set_mode(logic nullable, logic descending);
        wait_keys_drained();
        write_mode_reg(ske_pkg::REG_NULLABLE, nullable);
        write_mode_reg(ske_pkg::REG_DESCENDING, descending);
        cfg_valid <= 1'b0;
    endtask

    // Pick a value biased toward the encoding boundaries
    function automatic logic [ske_pkg::VALUE_W-1:0] pick_value();
        logic [ske_pkg::VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = {v[63], 63'd0};
            1: v = {v[63], 11'h7FF, v[51:0]};
            2: v = {v[63], 15'h7FFF, v[47:0]};
            3: v = {{60{v[63]}}, v[3:0]};
            4: v = {v[63], 62'd0, v[0]};
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_int_extremes();
        send_value(ske_pkg::CMD_INT, 64'h0000_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_INT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(ske_pkg::CMD_INT, 64'h8000_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_INT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(ske_pkg::CMD_INT, 64'h0000_0000_0000_0001, 1'b0);
    endtask

    task automatic test_double_special();
        send_value(ske_pkg::CMD_DOUBLE, 64'h0000_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h8000_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h7FF0_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'hFFF0_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h7FF8_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'hFFF8_0000_0000_0001, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h3FF0_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'hBFF0_0000_0000_0000, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h0000_0000_0000_0001, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'h8000_0000_0000_0001, 1'b0);
        // top 16 bits wrap when the exponent is raised
        send_value(ske_pkg::CMD_DOUBLE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(ske_pkg::CMD_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    endtask

    task automatic test_null_values();
        send_value(ske_pkg::CMD_INT, 64'h1234_5678_9ABC_DEF0, 1'b1);
        send_value(ske_pkg::CMD_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_value(ske_pkg::CMD_DOUBLE, 64'h0000_0000_0000_0000, 1'b1);
        send_value(ske_pkg::CMD_INT, 64'h8000_0000_0000_0000, 1'b1);
    endtask

    task automatic test_random_mixed(int count, bit drain_midway);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (drain_midway && i == count / 2)
                wait_keys_drained();
            send_value(1'($urandom_range(0, 1)), pick_value(), $urandom_range(0, 7) == 0);
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_int_extremes();
        set_mode(1'b1, 1'b1);
        test_double_special();
        test_null_values();

        set_mode(1'b0, 1'b0);
        test_random_mixed(190, 1'b1);
        set_mode(1'b1, 1'b0);
        test_random_mixed(190, 1'b0);
        set_mode(1'b0, 1'b1);
        test_random_mixed(190, 1'b0);
        set_mode(1'b1, 1'b1);
        test_random_mixed(190, 1'b1);
        set_mode(1'b1, 1'b0);
        no_idle = 1'b1;
        test_random_mixed(190, 1'b0);

        wait_keys_drained();
        if (mismatches == 0)
            $display("tb_sort_key_encoder: clean");
        else
            $display("tb_sort_key_encoder: errors");
        $finish;
    end

    // Random backpressure on the result side
    initial
    begin
        int n;
        forever
        begin
            if (no_idle)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge clk);
                if (!no_idle)
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 11);
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // Compare each result beat against the oldest expected key
    always @(posedge clk)
    begin
        sort_key_t got;
        sort_key_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.present = m_axis_tuser;
            got.marker  = m_axis_tdata[0];
            got.key     = m_axis_tdata[ske_pkg::KEY_W:1];
            if (key_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: present=%0b marker=%0b key=%h",
                             got.present, got.marker, got.key);
            end
            else
            begin
                want = key_expect_q.pop_front();
                if (got.present !== want.present || got.marker !== want.marker ||
                    got.key !== want.key)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("key mismatch: exp present=%0b marker=%0b key=%h, %s%0b %s%0b %s%h",
                                 want.present, want.marker, want.key,
                                 "got present=", got.present, "marker=", got.marker,
                                 "key=", got.key);
                end
            end
        end
    end

    // Bound the run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_sort_key_encoder: errors");
            $finish;
        end
    end

endmodule
